### rtl/hcg_pkg.sv
// Shared types, constants and helpers for the heat-to-color gradient block.
// No dependencies; every other file in rtl/ refers to this package.
`timescale 1ns / 1ps

package hcg_pkg;

    // Field widths
    localparam int HEAT_W    = 8;
    localparam int CH_W      = 8;
    localparam int STOP_W    = 32;
    localparam int PIX_W     = 32;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CH    = 3;
    localparam int PROD_W    = 2 * CH_W;

    // Largest number of stops the register map can address
    localparam int MAX_STOPS_DEF = 7;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BASE  = 3'd1;

    localparam logic [CNT_W-1:0]  STOP_COUNT_RST = 3'd7;
    localparam logic [CH_W-1:0]   ALPHA_OPAQUE   = 8'hFF;
    localparam logic [HEAT_W-1:0] IDX_FIRST      = 8'h00;
    localparam logic [HEAT_W-1:0] IDX_LAST       = 8'hFF;

    // Default palette, black through red and yellow to white
    localparam logic [STOP_W-1:0] STOP_RST [MAX_STOPS_DEF] = '{
        32'h0000_0000, 32'h202D_0000, 32'h5096_0000, 32'h88FF_2D00,
        32'hC0FF_A000, 32'hE8FF_F550, 32'hFFFF_FFFF
    };

    // Word moving through the segment search cells
    typedef struct packed {
        logic [HEAT_W-1:0] heat;
        logic [STOP_W-1:0] stop_a;
        logic [STOP_W-1:0] stop_b;
    } seg_t;

    // One color channel inside the divider cells
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [CH_W-1:0]   quo;
        logic [CH_W-1:0]   base;
        logic              neg;
    } lane_t;

    // Word moving through the divider cells; lane 0 is blue, 2 is red
    typedef struct packed {
        logic [HEAT_W-1:0]       span;
        lane_t [NUM_CH-1:0]      lane;
    } div_t;

    function automatic logic [HEAT_W-1:0] stop_idx(input logic [STOP_W-1:0] s);
        return s[STOP_W-1 -: HEAT_W];
    endfunction

endpackage

### rtl/hcg_if.sv
// Valid/ready channel interfaces for the heat-to-color gradient block.
// Depends on hcg_pkg for field widths.
`timescale 1ns / 1ps

// Heat sample channel
interface hcg_heat_if;
    logic                       valid;
    logic                       ready;
    logic [hcg_pkg::HEAT_W-1:0] heat;

    modport source (output valid, output heat, input ready);
    modport sink   (input valid, input heat, output ready);
endinterface

// Color result channel
interface hcg_color_if;
    logic                      valid;
    logic                      ready;
    logic [hcg_pkg::PIX_W-1:0] pixel;
    logic                      stops_invalid;

    modport source (output valid, output pixel, output stops_invalid, input ready);
    modport sink   (input valid, input pixel, input stops_invalid, output ready);
endinterface

// Configuration write channel
interface hcg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hcg_pkg::CFG_IDX_W-1:0] index;
    logic [hcg_pkg::STOP_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/hcg_seg_cell.sv
// Segment search cell: checks one stop against the heat value and keeps the
// bracketing pair when it qualifies. Depends on hcg_pkg.
`timescale 1ns / 1ps

module hcg_seg_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  hcg_pkg::seg_t              up_data,
    input  logic [hcg_pkg::STOP_W-1:0] cur_stop,
    input  logic [hcg_pkg::STOP_W-1:0] nxt_stop,
    input  logic                       in_use,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output hcg_pkg::seg_t              dn_data
);

    logic          vld_reg;
    hcg_pkg::seg_t data_reg;
    hcg_pkg::seg_t data_next;

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

    // Later cells override earlier ones: last stop at or below heat wins
    always_comb
    begin
        data_next = up_data;
        if (in_use && (hcg_pkg::stop_idx(cur_stop) <= up_data.heat))
        begin
            data_next.stop_a = cur_stop;
            data_next.stop_b = nxt_stop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/hcg_div_cell.sv
// Divider cell: one restoring-division step (one quotient bit) for all three
// color channels. Depends on hcg_pkg.
`timescale 1ns / 1ps

module hcg_div_cell #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  hcg_pkg::div_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output hcg_pkg::div_t dn_data
);

    logic                         vld_reg;
    hcg_pkg::div_t                data_reg;
    hcg_pkg::div_t                data_next;
    logic [hcg_pkg::PROD_W-1:0]   shifted;

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

    // Subtract the shifted divisor where it fits and set this quotient bit
    always_comb
    begin
        data_next = up_data;
        shifted   = hcg_pkg::PROD_W'(up_data.span) << BIT;
        for (int c = 0; c < hcg_pkg::NUM_CH; c++)
        begin
            if (up_data.lane[c].rem >= shifted)
            begin
                data_next.lane[c].rem      = up_data.lane[c].rem - shifted;
                data_next.lane[c].quo[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/heat_to_color_gradient.sv
// Top level of the heat-to-color gradient block: stop registers, segment
// search cells, channel prep, divider cells and the output register.
// Depends on hcg_pkg, hcg_if, hcg_seg_cell and hcg_div_cell.
`timescale 1ns / 1ps

// Maps an 8-bit heat word to an opaque ARGB pixel by linear interpolation
// between the configured gradient stops. One heat word is taken every cycle
// unless a stalled output has backed the pipeline up to the input. The depth
// is set by MAX_STOPS - 1 segment search cells, one channel prep stage,
// eight divider cells (one quotient bit each) and the output register.
// Each stage holds its word independently, so a stalled output
// only backs up the pipeline as it fills. When the stops are invalid (fewer
// than two, first index not 0, last not 255, indices not strictly rising) the
// pixel is zero and stops_invalid is set. Stops may be rewritten only while
// no words are in flight; cfg.ready is always high.

module heat_to_color_gradient #(
    parameter int MAX_STOPS = hcg_pkg::MAX_STOPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    hcg_heat_if.sink            sample,
    hcg_color_if.source         color,
    hcg_cfg_if.sink             cfg
);

    localparam int SEG_CELLS = MAX_STOPS - 1;
    localparam int DIV_CELLS = hcg_pkg::CH_W;

    // Configuration registers
    logic [hcg_pkg::CNT_W-1:0]  stop_count_reg;
    logic [hcg_pkg::STOP_W-1:0] stop_reg [MAX_STOPS];
    logic                       stops_ok_reg;
    logic                       stops_ok_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= hcg_pkg::STOP_COUNT_RST;
            for (int k = 0; k < MAX_STOPS; k++)
            begin
                stop_reg[k] <= hcg_pkg::STOP_RST[k];
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == hcg_pkg::REG_STOP_COUNT)
            begin
                stop_count_reg <= cfg.data[hcg_pkg::CNT_W-1:0];
            end
            for (int k = 0; k < MAX_STOPS; k++)
            begin
                if (cfg.index == hcg_pkg::REG_STOP_BASE + hcg_pkg::CFG_IDX_W'(k))
                begin
                    stop_reg[k] <= cfg.data;
                end
            end
        end
    end

    // Stop table check, registered; the user changes the table only while idle, which the block does not enforce
    always_comb
    begin
        stops_ok_next = (stop_count_reg >= 3'd2) &&
                        (stop_count_reg <= hcg_pkg::CNT_W'(MAX_STOPS)) &&
                        (hcg_pkg::stop_idx(stop_reg[0]) == hcg_pkg::IDX_FIRST);
        for (int k = 0; k < MAX_STOPS; k++)
        begin
            if ((stop_count_reg == hcg_pkg::CNT_W'(k + 1)) &&
                (hcg_pkg::stop_idx(stop_reg[k]) != hcg_pkg::IDX_LAST))
            begin
                stops_ok_next = 1'b0;
            end
        end
        for (int k = 0; k < MAX_STOPS - 1; k++)
        begin
            if ((hcg_pkg::CNT_W'(k + 1) < stop_count_reg) &&
                (hcg_pkg::stop_idx(stop_reg[k + 1]) <= hcg_pkg::stop_idx(stop_reg[k])))
            begin
                stops_ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stops_ok_reg <= 1'b0;
        end
        else
        begin
            stops_ok_reg <= stops_ok_next;
        end
    end

    // Segment search cells
    logic          seg_vld  [SEG_CELLS + 1];
    logic          seg_rdy  [SEG_CELLS + 1];
    hcg_pkg::seg_t seg_data [SEG_CELLS + 1];

    assign seg_vld[0]         = sample.valid;
    assign seg_data[0].heat   = sample.heat;
    assign seg_data[0].stop_a = '0;
    assign seg_data[0].stop_b = '0;
    assign sample.ready       = seg_rdy[0];

    for (genvar k = 0; k < SEG_CELLS; k++)
    begin : g_seg
        hcg_seg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (seg_vld[k]),
            .up_ready (seg_rdy[k]),
            .up_data  (seg_data[k]),
            .cur_stop (stop_reg[k]),
            .nxt_stop (stop_reg[k + 1]),
            .in_use   (hcg_pkg::CNT_W'(k + 1) < stop_count_reg),
            .dn_valid (seg_vld[k + 1]),
            .dn_ready (seg_rdy[k + 1]),
            .dn_data  (seg_data[k + 1])
        );
    end

    // Channel prep: offset, distance, |second - first| * offset per channel
    logic                        prep_vld_reg;
    hcg_pkg::div_t               prep_reg;
    hcg_pkg::div_t               prep_next;
    logic                        prep_rdy;
    logic [hcg_pkg::HEAT_W-1:0]  offset;
    logic [hcg_pkg::CH_W-1:0]    ca;
    logic [hcg_pkg::CH_W-1:0]    cb;
    logic [hcg_pkg::CH_W-1:0]    mag;
    logic                        div_rdy [DIV_CELLS + 1];

    assign prep_rdy           = !prep_vld_reg || div_rdy[0];
    assign seg_rdy[SEG_CELLS] = prep_rdy;

    always_comb
    begin
        offset = seg_data[SEG_CELLS].heat - hcg_pkg::stop_idx(seg_data[SEG_CELLS].stop_a);
        prep_next.span = hcg_pkg::stop_idx(seg_data[SEG_CELLS].stop_b)
                       - hcg_pkg::stop_idx(seg_data[SEG_CELLS].stop_a);
        ca  = '0;
        cb  = '0;
        mag = '0;
        for (int c = 0; c < hcg_pkg::NUM_CH; c++)
        begin
            ca  = seg_data[SEG_CELLS].stop_a[c * hcg_pkg::CH_W +: hcg_pkg::CH_W];
            cb  = seg_data[SEG_CELLS].stop_b[c * hcg_pkg::CH_W +: hcg_pkg::CH_W];
            mag = (cb < ca) ? (ca - cb) : (cb - ca);
            prep_next.lane[c].neg  = (cb < ca);
            prep_next.lane[c].base = ca;
            prep_next.lane[c].quo  = '0;
            prep_next.lane[c].rem  = hcg_pkg::PROD_W'(mag) * hcg_pkg::PROD_W'(offset);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
        end
        else if (prep_rdy)
        begin
            prep_vld_reg <= seg_vld[SEG_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep_rdy && seg_vld[SEG_CELLS])
        begin
            prep_reg <= prep_next;
        end
    end

    // Divider cells, most significant quotient bit first
    logic          div_vld  [DIV_CELLS + 1];
    hcg_pkg::div_t div_data [DIV_CELLS + 1];

    assign div_vld[0]  = prep_vld_reg;
    assign div_data[0] = prep_reg;

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        hcg_div_cell #(
            .BIT (DIV_CELLS - 1 - j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_vld[j]),
            .up_ready (div_rdy[j]),
            .up_data  (div_data[j]),
            .dn_valid (div_vld[j + 1]),
            .dn_ready (div_rdy[j + 1]),
            .dn_data  (div_data[j + 1])
        );
    end

    // Output register: first +/- quotient, truncated toward zero
    logic                       out_vld_reg;
    logic [hcg_pkg::PIX_W-1:0]  pixel_reg;
    logic [hcg_pkg::PIX_W-1:0]  pixel_next;
    logic                       invalid_reg;
    logic                       out_rdy;
    logic [hcg_pkg::CH_W-1:0]   chan;

    assign out_rdy              = !out_vld_reg || color.ready;
    assign div_rdy[DIV_CELLS]   = out_rdy;
    assign color.valid          = out_vld_reg;
    assign color.pixel          = pixel_reg;
    assign color.stops_invalid  = invalid_reg;

    always_comb
    begin
        pixel_next = '0;
        chan       = '0;
        pixel_next[hcg_pkg::PIX_W-1 -: hcg_pkg::CH_W] = hcg_pkg::ALPHA_OPAQUE;
        for (int c = 0; c < hcg_pkg::NUM_CH; c++)
        begin
            chan = div_data[DIV_CELLS].lane[c].neg
                 ? div_data[DIV_CELLS].lane[c].base - div_data[DIV_CELLS].lane[c].quo
                 : div_data[DIV_CELLS].lane[c].base + div_data[DIV_CELLS].lane[c].quo;
            pixel_next[c * hcg_pkg::CH_W +: hcg_pkg::CH_W] = chan;
        end
        if (!stops_ok_reg)
        begin
            pixel_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_vld_reg <= div_vld[DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && div_vld[DIV_CELLS])
        begin
            pixel_reg   <= pixel_next;
            invalid_reg <= !stops_ok_reg;
        end
    end

endmodule

### tb/hcg_color_checker.sv
// Scoreboard for heat_to_color_gradient: watches the heat, color and config channels,
// keeps a shadow of the stop registers, predicts each color word and compares it.
// Depends on hcg_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module hcg_color_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          heat_valid,
    input  logic                          heat_ready,
    input  logic [hcg_pkg::HEAT_W-1:0]    heat,
    input  logic                          color_valid,
    input  logic                          color_ready,
    input  logic [hcg_pkg::PIX_W-1:0]     pixel,
    input  logic                          stops_invalid,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [hcg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcg_pkg::STOP_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            outstanding
);

    typedef struct packed {
        logic [hcg_pkg::PIX_W-1:0] pixel;
        logic                      invalid;
    } color_word_t;

    // Shadow of the gradient registers
    logic [hcg_pkg::CNT_W-1:0]  grad_count;
    logic [hcg_pkg::STOP_W-1:0] grad_stop [hcg_pkg::MAX_STOPS_DEF];

    color_word_t expected_colors [$];
    int          colors_seen;

    // Color of one heat level under the current shadow registers
    function automatic color_word_t interpolate_color(
        input logic [hcg_pkg::HEAT_W-1:0] level
    );
        color_word_t                c;
        logic                       ok;
        int                         seg;
        int                         off;
        int                         span;
        int                         ca;
        int                         cb;
        int                         v;
        logic [hcg_pkg::STOP_W-1:0] a;
        logic [hcg_pkg::STOP_W-1:0] b;
        c = '0;
        ok = (grad_count >= 2) && (int'(grad_count) <= hcg_pkg::MAX_STOPS_DEF);
        if (ok)
        begin
            if (grad_stop[0][31:24] != hcg_pkg::IDX_FIRST)
                ok = 1'b0;
            if (grad_stop[grad_count - 1][31:24] != hcg_pkg::IDX_LAST)
                ok = 1'b0;
            for (int k = 0; k + 1 < int'(grad_count); k++)
                if (grad_stop[k + 1][31:24] <= grad_stop[k][31:24])
                    ok = 1'b0;
        end
        if (!ok)
        begin
            c.invalid = 1'b1;
            return c;
        end
        // last segment starting at or below the heat level
        seg = 0;
        for (int k = 0; k + 1 < int'(grad_count); k++)
            if (grad_stop[k][31:24] <= level)
                seg = k;
        a = grad_stop[seg];
        b = grad_stop[seg + 1];
        off  = int'(level) - int'(a[31:24]);
        span = int'(b[31:24]) - int'(a[31:24]);
        for (int ch = 0; ch < hcg_pkg::NUM_CH; ch++)
        begin
            ca = int'(a[8*ch +: 8]);
            cb = int'(b[8*ch +: 8]);
            // int division truncates toward zero, as the block does
            v = ca + ((cb - ca) * off) / span;
            c.pixel[8*ch +: 8] = 8'(v);
        end
        c.pixel[31:24] = hcg_pkg::ALPHA_OPAQUE;
        return c;
    endfunction

    initial mismatches = 0;

    // Track config, queue predictions, score results
    always @(posedge clk or negedge rst_n)
    begin
        color_word_t want;
        if (!rst_n)
        begin
            grad_count <= hcg_pkg::STOP_COUNT_RST;
            for (int k = 0; k < hcg_pkg::MAX_STOPS_DEF; k++)
                grad_stop[k] <= hcg_pkg::STOP_RST[k];
            expected_colors.delete();
            colors_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (heat_valid && heat_ready)
                expected_colors.push_back(interpolate_color(heat));
            if (color_valid && color_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected color word: pixel %08h stops_invalid %0b",
                                 pixel, stops_invalid);
                    mismatches++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (want.pixel !== pixel || want.invalid !== stops_invalid)
                    begin
                        if (mismatches < 10)
                            $display({"color word %0d: expected pixel %08h ",
                                      "stops_invalid %0b, got pixel %08h ",
                                      "stops_invalid %0b"},
                                     colors_seen, want.pixel, want.invalid,
                                     pixel, stops_invalid);
                        mismatches++;
                    end
                end
                colors_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == hcg_pkg::REG_STOP_COUNT)
                    grad_count <= cfg_data[hcg_pkg::CNT_W-1:0];
                else
                    grad_stop[cfg_index - hcg_pkg::REG_STOP_BASE] <= cfg_data;
            end
            outstanding <= expected_colors.size();
        end
    end

endmodule

### tb/tb_heat_to_color_gradient.sv
// Testbench top for heat_to_color_gradient: drives heat words and gradient configs,
// applies idle and backpressure patterns, and gives the verdict.
// Depends on hcg_pkg, hcg_if, the block itself and hcg_color_checker.
`timescale 1ns / 1ps

module tb_heat_to_color_gradient;

    localparam int PIPE_LATENCY    = hcg_pkg::MAX_STOPS_DEF + 9;
    // quiet stretches stay well under this: the pressure hold plus pipe depth
    // plus random gaps
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASES          = 20;
    localparam int WORDS_PER_PHASE = 55;
    localparam int HOLD_CYCLES     = 80;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {
        BROKEN_EMPTY, BROKEN_SINGLE, BROKEN_FIRST, BROKEN_LAST, BROKEN_TIE, BROKEN_DESCEND
    } broken_kind_t;

    // Heat levels around the default palette's stops
    localparam logic [hcg_pkg::HEAT_W-1:0] DIRECTED_HEATS [12] = '{
        8'h00, 8'hFF, 8'h01, 8'h1F, 8'h20, 8'h21,
        8'h50, 8'h88, 8'hC0, 8'hE7, 8'hE8, 8'hFE
    };

    logic clk;
    logic rst_n;

    hcg_heat_if  sample_ch ();
    hcg_color_if color_ch ();
    hcg_cfg_if   cfg_ch ();

    int mismatches;
    int outstanding;

    // Stimulus copy of the palette being programmed
    logic [hcg_pkg::CNT_W-1:0]  pal_count;
    logic [hcg_pkg::STOP_W-1:0] pal_stop [hcg_pkg::MAX_STOPS_DEF];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic pressure_armed = 1'b0;

    heat_to_color_gradient uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .color  (color_ch),
        .cfg    (cfg_ch)
    );

    hcg_color_checker color_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .heat_valid    (sample_ch.valid),
        .heat_ready    (sample_ch.ready),
        .heat          (sample_ch.heat),
        .color_valid   (color_ch.valid),
        .color_ready   (color_ch.ready),
        .pixel         (color_ch.pixel),
        .stops_invalid (color_ch.stops_invalid),
        .cfg_valid     (cfg_ch.valid),
        .cfg_ready     (cfg_ch.ready),
        .cfg_index     (cfg_ch.index),
        .cfg_data      (cfg_ch.data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold each time pressure becomes armed
    initial
    begin
        int   hold;
        logic armed_seen;
        hold = 0;
        armed_seen = 1'b0;
        color_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_armed && !armed_seen)
                hold = HOLD_CYCLES;
            armed_seen = pressure_armed;
            if (hold > 0)
            begin
                color_ch.ready <= 1'b0;
                hold--;
            end
            else
                color_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no word moving on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (color_ch.valid && color_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("heat_to_color_gradient regression: fail");
        $finish;
    end

    // One config write; valid stays high for a following write
    task automatic write_reg(input logic [hcg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hcg_pkg::STOP_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Write every register from the stimulus palette copy
    task automatic apply_palette();
        write_reg(hcg_pkg::REG_STOP_COUNT, hcg_pkg::STOP_W'(pal_count));
        for (int k = 0; k < hcg_pkg::MAX_STOPS_DEF; k++)
            write_reg(hcg_pkg::REG_STOP_BASE + hcg_pkg::CFG_IDX_W'(k), pal_stop[k]);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering heat and wait until every color word has come back
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Offer one heat word after random sender idle, wait for acceptance
    task automatic send_heat(input logic [hcg_pkg::HEAT_W-1:0] level);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.heat  <= level;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    // Valid gradient of n stops: indices 0 and 255 plus distinct random ones
    task automatic build_ramp(input int n);
        logic [255:0] used;
        int           picked;
        int           idx;
        int           k;
        used = '0;
        used[0] = 1'b1;
        used[255] = 1'b1;
        picked = 2;
        while (picked < n)
        begin
            idx = $urandom_range(254, 1);
            if (!used[idx])
            begin
                used[idx] = 1'b1;
                picked++;
            end
        end
        for (int s = 0; s < hcg_pkg::MAX_STOPS_DEF; s++)
            pal_stop[s] = $urandom;
        k = 0;
        for (int i = 0; i < 256; i++)
            if (used[i])
            begin
                pal_stop[k] = {8'(i), 24'($urandom)};
                k++;
            end
        pal_count = hcg_pkg::CNT_W'(n);
    endtask

    // Gradient with one defect of the given kind
    task automatic build_broken(input broken_kind_t kind);
        int n;
        int k;
        logic [hcg_pkg::HEAT_W-1:0] swap;
        n = $urandom_range(hcg_pkg::MAX_STOPS_DEF, 4);
        build_ramp(n);
        case (kind)
            BROKEN_EMPTY:  pal_count = '0;
            BROKEN_SINGLE: pal_count = hcg_pkg::CNT_W'(1);
            BROKEN_FIRST:  pal_stop[0][31:24] = 8'($urandom_range(255, 1));
            BROKEN_LAST:   pal_stop[n - 1][31:24] = 8'($urandom_range(254, 0));
            BROKEN_TIE:
            begin
                k = $urandom_range(n - 3, 0);
                pal_stop[k + 1][31:24] = pal_stop[k][31:24];
            end
            default:
            begin
                k = $urandom_range(n - 3, 1);
                swap = pal_stop[k][31:24];
                pal_stop[k][31:24] = pal_stop[k + 1][31:24];
                pal_stop[k + 1][31:24] = swap;
            end
        endcase
    endtask

    // Heat pick biased toward stop indices, their neighbors and the ends
    function automatic logic [hcg_pkg::HEAT_W-1:0] pick_heat();
        int r;
        logic [hcg_pkg::HEAT_W-1:0] at;
        r = $urandom_range(99);
        at = pal_stop[$urandom_range(hcg_pkg::MAX_STOPS_DEF - 1)][31:24];
        if (pal_count > 0)
            at = pal_stop[$urandom_range(int'(pal_count) - 1)][31:24];
        if (r < 25)
            return at;
        if (r < 35)
            return at + 8'($urandom_range(1) ? 1 : -1);
        if (r < 45)
            return $urandom_range(1) ? hcg_pkg::IDX_LAST : hcg_pkg::IDX_FIRST;
        return 8'($urandom);
    endfunction

    // Main stimulus
    initial
    begin
        idle_mode_t mode;
        rst_n <= 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.heat  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= hcg_pkg::REG_STOP_COUNT;
        cfg_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // default palette straight out of reset
        pal_count = hcg_pkg::STOP_COUNT_RST;
        for (int k = 0; k < hcg_pkg::MAX_STOPS_DEF; k++)
            pal_stop[k] = hcg_pkg::STOP_RST[k];
        foreach (DIRECTED_HEATS[i])
            send_heat(DIRECTED_HEATS[i]);

        // two stops, white down to black: falling channels, minimum count
        drain_results();
        build_ramp(2);
        pal_stop[0] = {hcg_pkg::IDX_FIRST, 24'hFF_FFFF};
        pal_stop[1] = {hcg_pkg::IDX_LAST, 24'h00_0000};
        apply_palette();
        send_heat(8'h00);
        send_heat(8'h01);
        send_heat(8'h7F);
        send_heat(8'hFE);
        send_heat(8'hFF);

        // each kind of broken stop list
        for (int k = BROKEN_EMPTY; k <= BROKEN_DESCEND; k++)
        begin
            drain_results();
            build_broken(broken_kind_t'(k));
            apply_palette();
            send_heat(pick_heat());
        end

        // random phases, idle mode rotating
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    // seven stops, distance one between the first six
                    build_ramp(hcg_pkg::MAX_STOPS_DEF);
                    for (int k = 0; k < hcg_pkg::MAX_STOPS_DEF - 1; k++)
                        pal_stop[k][31:24] = 8'(k);
                end
                1:
                begin
                    build_ramp(2);
                    pal_stop[0] = {hcg_pkg::IDX_FIRST, 24'h00_0000};
                    pal_stop[1] = {hcg_pkg::IDX_LAST, 24'hFF_FFFF};
                end
                2:       build_ramp(hcg_pkg::MAX_STOPS_DEF);
                default:
                    if ($urandom_range(99) < 15)
                        build_broken(broken_kind_t'($urandom_range(BROKEN_DESCEND)));
                    else
                        build_ramp($urandom_range(hcg_pkg::MAX_STOPS_DEF, 2));
            endcase
            apply_palette();
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 56; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default:       begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            // long output hold while heat keeps coming, fills the pipe
            pressure_armed = (p == 4 || p == 12);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                send_heat(pick_heat());
            pressure_armed = 1'b0;
        end

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("heat_to_color_gradient regression: pass");
        else
            $display("heat_to_color_gradient regression: fail");
        $finish;
    end

endmodule

### heat_to_color_gradient.f
rtl/hcg_pkg.sv
rtl/hcg_if.sv
rtl/hcg_seg_cell.sv
rtl/hcg_div_cell.sv
rtl/heat_to_color_gradient.sv
tb/hcg_color_checker.sv
tb/tb_heat_to_color_gradient.sv
